// File: src/aepq_pkg.sv
// Shared types and constants of the active/expired priority queue block.
// No dependencies; used by active_expired_priority_queues (aepq_qtab uses no package).
package aepq_pkg;

   // parameter defaults
   localparam int unsigned DEF_MAX_LEVELS  = 8;
   localparam int unsigned DEF_QUEUE_DEPTH = 16;
   localparam int unsigned DEF_ID_BITS     = 8;

   // field widths on the ports
   localparam int unsigned ID_W       = 8;
   localparam int unsigned LEVEL_W    = 3;
   localparam int unsigned STATIC_W   = 4;
   localparam int unsigned CFG_W      = 4;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned TOTAL_BITS = 9;
   localparam int unsigned LEV_CMP_W  = 5;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      MODE_ADD = 1'b0,
      MODE_GET = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EXEC  = 2'd1,
      ST_FETCH = 2'd2
   } state_type;

endpackage

// File: src/aepq_qtab.sv
// Queue state table: one row {head, tail, fill} per queue, registered read.
// Rows never written read as zero through per-row valid bits. Uses no package.
module aepq_qtab #(
   parameter int unsigned ADDR_BITS = 4,
   parameter int unsigned ROW_BITS  = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [ROW_BITS-1:0]  rd_row,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]  wr_row
);

   localparam int unsigned ROWS = 1 << ADDR_BITS;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROWS-1:0]     valid_ff;
   logic [ROWS-1:0]     valid_in;
   logic [ROW_BITS-1:0] row_ff;
   logic                hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = hit_ff ? row_ff : '0;

endmodule

// File: src/active_expired_priority_queues.sv
// Top level of the active/expired multilevel priority queue of process ids.
// Depends on aepq_pkg and aepq_qtab.
//
// Use:
//   req_ channel: one request word per add or get. req_tuser is the mode
//   (add or get); req_tdata carries the process fields of an add.
//   rsp_ channel: exactly one response word per request, in request order.
//   csr_ channel: writes num_levels; the user must write only while no request is in flight (not enforced).
// Sequence:
//   An add goes from accept to response as follows: the queue state row is
//   read from the table memory, then the id and the updated row are written.
//   A get that finds a process: row read, then id memory read at the head
//   pointer, then response. A get that finds nothing responds after the row read.
//   One request is in flight at a time; the next is accepted the cycle after
//   the response is loaded into the output register.
// Reset:
//   All queues empty, bank zero active, counts zero, num_levels 4. Table rows
//   carry valid bits, so no clearing pass is needed; the id memory is not reset.
// Receiver stall:
//   The response waits in the output register and a new request is still
//   accepted; its completion holds (no memory update) until the register frees.
module active_expired_priority_queues #(
   parameter int unsigned MAX_LEVELS  = aepq_pkg::DEF_MAX_LEVELS,
   parameter int unsigned QUEUE_DEPTH = aepq_pkg::DEF_QUEUE_DEPTH,
   parameter int unsigned ID_BITS     = aepq_pkg::DEF_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: [7:0] process_id, [10:8] dynamic_priority,
   //          [14:11] static_priority, [15] was_preempted
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [aepq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [0:0]                        req_tuser,   // [0] mode
   // response: [0] grant_valid, [8:1] grant_id, [11:9] grant_level,
   //           [14:12] new_dynamic_priority, [15] to_expired, [17:16] status
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [aepq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // num_levels write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aepq_pkg::CFG_W-1:0]        csr_data
);

   localparam int unsigned LVL_BITS  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int unsigned Q_BITS    = LVL_BITS + 1;
   localparam int unsigned PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int unsigned FILL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned ROW_BITS  = 2 * PTR_BITS + FILL_BITS;
   localparam int unsigned MEM_ABITS = Q_BITS + PTR_BITS;
   localparam int unsigned MEM_DEPTH = 1 << MEM_ABITS;
   localparam int unsigned NQ_SLOTS  = 1 << Q_BITS;
   localparam int unsigned IDX_W     = (ID_BITS > aepq_pkg::ID_W) ? ID_BITS : aepq_pkg::ID_W;
   localparam int unsigned GL_W      = (LVL_BITS > aepq_pkg::LEVEL_W) ? LVL_BITS
                                                                     : aepq_pkg::LEVEL_W;
   localparam int unsigned LC_W      = aepq_pkg::LEV_CMP_W;
   localparam int unsigned TB        = aepq_pkg::TOTAL_BITS;

   // request fields
   logic                              req_mode;
   logic [aepq_pkg::ID_W-1:0]         req_id;
   logic [aepq_pkg::LEVEL_W-1:0]      req_dyn;
   logic [aepq_pkg::STATIC_W-1:0]     req_stat;
   logic                              req_pre;

   assign req_mode = req_tuser[0];
   assign req_id   = req_tdata[7:0];
   assign req_dyn  = req_tdata[10:8];
   assign req_stat = req_tdata[14:11];
   assign req_pre  = req_tdata[15];

   // control state
   aepq_pkg::state_type           state_ff, state_in;
   logic [aepq_pkg::CFG_W-1:0]    num_levels_ff;
   logic                          bank_ff, bank_in;
   logic [TB-1:0]                 active_total_ff, active_total_in;
   logic [TB-1:0]                 expired_total_ff, expired_total_in;
   logic [NQ_SLOTS-1:0]           nonempty_ff, nonempty_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // operation context, captured at accept
   logic                          op_mode_ff, op_mode_in;
   logic [Q_BITS-1:0]             op_q_ff, op_q_in;
   logic                          op_ok_ff, op_ok_in;
   logic                          op_toexp_ff, op_toexp_in;
   logic [aepq_pkg::LEVEL_W-1:0]  op_ndp_ff, op_ndp_in;
   logic [ID_BITS-1:0]            op_id_ff, op_id_in;

   // response register
   logic                          out_gv_ff, out_gv_in;
   logic [aepq_pkg::ID_W-1:0]     out_gid_ff, out_gid_in;
   logic [aepq_pkg::LEVEL_W-1:0]  out_glev_ff, out_glev_in;
   logic [aepq_pkg::LEVEL_W-1:0]  out_ndp_ff, out_ndp_in;
   logic                          out_toexp_ff, out_toexp_in;
   aepq_pkg::status_type          out_status_ff, out_status_in;

   // memories
   logic [ID_BITS-1:0]            id_mem [MEM_DEPTH];
   logic [ID_BITS-1:0]            id_rd_ff;
   logic                          id_we, id_re;
   logic [MEM_ABITS-1:0]          id_waddr, id_raddr;

   logic                          tab_rd_en, tab_wr_en;
   logic [Q_BITS-1:0]             tab_rd_addr;
   logic [ROW_BITS-1:0]           tab_rd_row, tab_wr_row;

   // decode helpers
   logic                          accept, out_free;
   logic [LC_W-1:0]               eff_levels;
   logic                          expired_path, add_in_range;
   logic [LC_W-1:0]               add_lvl;
   logic                          add_bank, get_bank, swap;
   logic                          found;
   logic [LVL_BITS-1:0]           found_lvl;
   logic [IDX_W-1:0]              id_wide, id_rd_wide;
   logic [GL_W-1:0]               glev_wide;
   logic [PTR_BITS-1:0]           row_head, row_tail, head_next, tail_next;
   logic [FILL_BITS-1:0]          row_fill;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == aepq_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   assign row_head  = tab_rd_row[ROW_BITS-1 -: PTR_BITS];
   assign row_tail  = tab_rd_row[FILL_BITS+PTR_BITS-1 -: PTR_BITS];
   assign row_fill  = tab_rd_row[FILL_BITS-1:0];
   assign head_next = (row_head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : row_head + 1'b1;
   assign tail_next = (row_tail == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : row_tail + 1'b1;

   assign id_wide    = IDX_W'(req_id);
   assign id_rd_wide = IDX_W'(id_rd_ff);
   assign glev_wide  = GL_W'(op_q_ff[LVL_BITS-1:0]);

   // level count: 0 acts as 1, saturate at MAX_LEVELS
   always_comb begin
      if (num_levels_ff == '0) begin
         eff_levels = LC_W'(1);
      end else if (LC_W'(num_levels_ff) > LC_W'(MAX_LEVELS)) begin
         eff_levels = LC_W'(MAX_LEVELS);
      end else begin
         eff_levels = LC_W'(num_levels_ff);
      end
   end

   // add target: preempted at level zero falls to the expired bank
   always_comb begin
      expired_path = req_pre && (req_dyn == '0);
      if (expired_path) begin
         add_lvl = LC_W'(req_stat) - LC_W'(1);
      end else begin
         add_lvl = LC_W'(req_dyn) - LC_W'(req_pre);
      end
      add_in_range = !(expired_path && (req_stat == '0)) && (add_lvl < eff_levels);
      add_bank     = bank_ff ^ expired_path;
   end

   // get: swap first when active is empty, then take the highest nonempty level
   always_comb begin
      swap      = (active_total_ff == '0);
      get_bank  = bank_ff ^ swap;
      found     = 1'b0;
      found_lvl = '0;
      for (int lev = 0; lev < MAX_LEVELS; lev++) begin
         if (nonempty_ff[{get_bank, LVL_BITS'(lev)}]) begin
            found     = 1'b1;
            found_lvl = LVL_BITS'(lev);
         end
      end
   end

   // sequencer: next state, memory controls, register updates
   always_comb begin
      state_in         = state_ff;
      bank_in          = bank_ff;
      active_total_in  = active_total_ff;
      expired_total_in = expired_total_ff;
      nonempty_in      = nonempty_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      op_mode_in  = op_mode_ff;
      op_q_in     = op_q_ff;
      op_ok_in    = op_ok_ff;
      op_toexp_in = op_toexp_ff;
      op_ndp_in   = op_ndp_ff;
      op_id_in    = op_id_ff;

      out_gv_in     = out_gv_ff;
      out_gid_in    = out_gid_ff;
      out_glev_in   = out_glev_ff;
      out_ndp_in    = out_ndp_ff;
      out_toexp_in  = out_toexp_ff;
      out_status_in = out_status_ff;

      tab_rd_en   = 1'b0;
      tab_rd_addr = '0;
      tab_wr_en   = 1'b0;
      tab_wr_row  = tab_rd_row;
      id_we       = 1'b0;
      id_re       = 1'b0;
      id_waddr    = {op_q_ff, row_tail};
      id_raddr    = {op_q_ff, row_head};

      case (state_ff)
         aepq_pkg::ST_IDLE: begin
            if (accept) begin
               op_mode_in = req_mode;
               op_id_in   = id_wide[ID_BITS-1:0];
               if (req_mode == aepq_pkg::MODE_ADD) begin
                  op_q_in     = {add_bank, add_lvl[LVL_BITS-1:0]};
                  op_ok_in    = add_in_range;
                  op_toexp_in = add_in_range && expired_path;
                  op_ndp_in   = add_in_range ? add_lvl[aepq_pkg::LEVEL_W-1:0] : '0;
               end else begin
                  op_q_in     = {get_bank, found_lvl};
                  op_ok_in    = found;
                  op_toexp_in = 1'b0;
                  op_ndp_in   = '0;
                  if (swap) begin
                     bank_in          = ~bank_ff;
                     active_total_in  = expired_total_ff;
                     expired_total_in = '0;
                  end
               end
               tab_rd_en   = 1'b1;
               tab_rd_addr = op_q_in;
               state_in    = aepq_pkg::ST_EXEC;
            end
         end

         aepq_pkg::ST_EXEC: begin
            if (out_free) begin
               out_gv_in     = 1'b0;
               out_gid_in    = '0;
               out_glev_in   = '0;
               out_ndp_in    = op_ndp_ff;
               out_toexp_in  = op_toexp_ff;
               out_status_in = aepq_pkg::STATUS_OK;
               if (op_mode_ff == aepq_pkg::MODE_ADD) begin
                  rsp_valid_in = 1'b1;
                  state_in     = aepq_pkg::ST_IDLE;
                  if (!op_ok_ff) begin
                     out_status_in = aepq_pkg::STATUS_RANGE;
                  end else if (row_fill == FILL_BITS'(QUEUE_DEPTH)) begin
                     out_status_in = aepq_pkg::STATUS_FULL;
                  end else begin
                     id_we                = 1'b1;
                     tab_wr_en            = 1'b1;
                     tab_wr_row           = {row_head, tail_next, row_fill + 1'b1};
                     nonempty_in[op_q_ff] = 1'b1;
                     if (op_toexp_ff) begin
                        expired_total_in = expired_total_ff + 1'b1;
                     end else begin
                        active_total_in = active_total_ff + 1'b1;
                     end
                  end
               end else if (op_ok_ff) begin
                  // pop: read the id at head, advance head
                  id_re                = 1'b1;
                  tab_wr_en            = 1'b1;
                  tab_wr_row           = {head_next, row_tail, row_fill - 1'b1};
                  nonempty_in[op_q_ff] = (row_fill != FILL_BITS'(1));
                  if (active_total_ff != '0) begin
                     active_total_in = active_total_ff - 1'b1;
                  end
                  state_in = aepq_pkg::ST_FETCH;
               end else begin
                  out_ndp_in   = '0;
                  out_toexp_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = aepq_pkg::ST_IDLE;
               end
            end
         end

         aepq_pkg::ST_FETCH: begin
            if (out_free) begin
               out_gv_in     = 1'b1;
               out_gid_in    = id_rd_wide[aepq_pkg::ID_W-1:0];
               out_glev_in   = glev_wide[aepq_pkg::LEVEL_W-1:0];
               out_ndp_in    = '0;
               out_toexp_in  = 1'b0;
               out_status_in = aepq_pkg::STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = aepq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = aepq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= aepq_pkg::ST_IDLE;
         num_levels_ff    <= aepq_pkg::CFG_RESET;
         bank_ff          <= 1'b0;
         active_total_ff  <= '0;
         expired_total_ff <= '0;
         nonempty_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         bank_ff          <= bank_in;
         active_total_ff  <= active_total_in;
         expired_total_ff <= expired_total_in;
         nonempty_ff      <= nonempty_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            num_levels_ff <= csr_data;
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      op_mode_ff    <= op_mode_in;
      op_q_ff       <= op_q_in;
      op_ok_ff      <= op_ok_in;
      op_toexp_ff   <= op_toexp_in;
      op_ndp_ff     <= op_ndp_in;
      op_id_ff      <= op_id_in;
      out_gv_ff     <= out_gv_in;
      out_gid_ff    <= out_gid_in;
      out_glev_ff   <= out_glev_in;
      out_ndp_ff    <= out_ndp_in;
      out_toexp_ff  <= out_toexp_in;
      out_status_ff <= out_status_in;
   end

   // id store: one write, one read per cycle, registered read
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= op_id_ff;
      end
      if (id_re) begin
         id_rd_ff <= id_mem[id_raddr];
      end
   end

   aepq_qtab #(
      .ADDR_BITS (Q_BITS),
      .ROW_BITS  (ROW_BITS)
   ) u_qtab (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_row  (tab_rd_row),
      .wr_en   (tab_wr_en),
      .wr_addr (op_q_ff),
      .wr_row  (tab_wr_row)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_status_ff, out_toexp_ff, out_ndp_ff, out_glev_ff,
                        out_gid_ff, out_gv_ff};

endmodule
